// ===== rtl/bsv_pkg.sv =====
// Shared types and constants for the bencode stream validator.
package bsv_pkg;

  // Default sizing of the nesting stack and of the string length counter.
  localparam int STACK_DEPTH_DEFAULT = 128;
  localparam int LENGTH_BITS_DEFAULT = 32;

  // Parser modes, one-hot.
  typedef enum logic [7:0] {
    M_IDLE     = 8'b0000_0001,
    M_ELEM     = 8'b0000_0010,
    M_VALUE    = 8'b0000_0100,
    M_INT_SIGN = 8'b0000_1000,
    M_INT_NEG  = 8'b0001_0000,
    M_INT_DIG  = 8'b0010_0000,
    M_STR_LEN  = 8'b0100_0000,
    M_STR_BODY = 8'b1000_0000
  } mode_t;

  // Status codes of a result.
  localparam logic [1:0] ST_BUSY = 2'd0;
  localparam logic [1:0] ST_DONE = 2'd1;
  localparam logic [1:0] ST_ERR  = 2'd2;

  // Top-level object kinds.
  localparam logic [1:0] KIND_STRING  = 2'd0;
  localparam logic [1:0] KIND_INTEGER = 2'd1;
  localparam logic [1:0] KIND_LIST    = 2'd2;
  localparam logic [1:0] KIND_DICT    = 2'd3;

  // Configuration register indexes.
  localparam logic CFG_DEPTH_LIMIT       = 1'b0;
  localparam logic CFG_MAX_STRING_LENGTH = 1'b1;

  // Reset values of the configuration registers.
  localparam logic [6:0]  DEPTH_LIMIT_RESET       = 7'd127;
  localparam logic [31:0] MAX_STRING_LENGTH_RESET = 32'hFFFF_FFFE;

  // Characters of the encoding.
  localparam logic [7:0] CH_E     = 8'h65;
  localparam logic [7:0] CH_D     = 8'h64;
  localparam logic [7:0] CH_L     = 8'h6C;
  localparam logic [7:0] CH_I     = 8'h69;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_1     = 8'h31;
  localparam logic [7:0] CH_9     = 8'h39;

  // One result transaction.
  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] object_bytes;
    logic [1:0]  object_kind;
    logic [6:0]  nesting;
  } res_t;

endpackage

// ===== rtl/bencode_stream_validator_unit.sv =====
// Streaming bencode validator: byte parser, nesting stack memory and output buffer.
//
// Usage: bytes arrive on the item channel (data_byte, end_of_input with
// item_valid / item_ready). Every accepted byte yields exactly one result
// transaction on the result channel (status, object_bytes, object_kind,
// nesting with result_valid / result_ready), in byte order.
// The result of an accepted byte is registered in the output register, or in
// the skid register when that one holds a result not yet taken. Throughput is
// one byte per cycle while item_ready is high; the parser state update and the
// single stack memory access of a byte both fit in that cycle, and the registered
// stack read is kept one step ahead by addressing it with the next stack pointer,
// with write data forwarded when a push lands on the entry being read.
// The result side has an output register and a skid register, so a byte is
// still taken while one result waits; item_ready falls only when both are
// full, and rises again once the receiver takes a result.
// Configuration (depth_limit, max_string_length) comes through cfg_write /
// cfg_index / cfg_data; the user must write it while no object is in progress,
// as the block does not enforce this. Reset (synchronous, active high) returns
// the parser to expect a new object, empties the output buffer and restores
// the register defaults. The stack memory needs no clearing, since an entry is
// always pushed before it is read.
module bencode_stream_validator_unit
  import bsv_pkg::*;
#(
  parameter int STACK_DEPTH = STACK_DEPTH_DEFAULT,
  parameter int LENGTH_BITS = LENGTH_BITS_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic        cfg_index,
  input  logic [31:0] cfg_data,
  input  logic        item_valid,
  output logic        item_ready,
  input  logic [7:0]  data_byte,
  input  logic        end_of_input,
  output logic        result_valid,
  input  logic        result_ready,
  output logic [1:0]  status,
  output logic [31:0] object_bytes,
  output logic [1:0]  object_kind,
  output logic [6:0]  nesting
);

  localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int DW = (AW > 7) ? AW : 7;
  localparam int NW = LENGTH_BITS + 4;
  localparam int CW = (NW > 32) ? NW : 33;

  // Configuration registers.
  logic [6:0]  depth_limit;
  logic [31:0] max_string_length;

  // Parser state.
  mode_t                  mode;
  logic [AW-1:0]          sp;
  logic [LENGTH_BITS-1:0] rem;
  logic                   is_key;
  logic [31:0]            bcnt;
  logic [1:0]             tkind;

  // Next-state values.
  mode_t                  mode_next;
  logic [AW-1:0]          sp_next;
  logic [LENGTH_BITS-1:0] rem_next;
  logic                   is_key_next;
  logic [31:0]            bcnt_next;
  logic [1:0]             tkind_next;
  logic [1:0]             status_next;

  // Stack memory and its read path.
  logic          kind_stack [STACK_DEPTH];
  logic          rd_q;
  logic          fwd_q;
  logic          fwd_data_q;
  logic          top_bit;
  logic          push;
  logic [AW-1:0] waddr;
  logic          wdata;
  logic [AW-1:0] sp_eff;
  logic [AW-1:0] raddr;

  // Output buffer.
  res_t main_q;
  res_t skid_q;
  logic main_v;
  logic skid_v;
  res_t res_new;

  logic accept;
  logic out_fire;

  // Byte decode and string length arithmetic.
  logic                   is_dig;
  logic [3:0]             dval;
  logic [NW-1:0]          rem_ext;
  logic [NW-1:0]          len_n;
  logic                   too_long;

  assign accept   = item_valid && item_ready;
  assign out_fire = main_v && result_ready;
  assign top_bit  = fwd_q ? fwd_data_q : rd_q;

  assign is_dig  = (data_byte >= CH_0) && (data_byte <= CH_9);
  assign dval    = 4'(data_byte - CH_0);
  assign rem_ext = NW'(rem);
  assign len_n   = ((mode == M_STR_LEN) ? ((rem_ext << 3) + (rem_ext << 1)) : '0) + NW'(dval);
  assign too_long = (CW'(len_n) > CW'({LENGTH_BITS{1'b1}})) ||
                    (CW'(len_n) > CW'(max_string_length));

  // Parser next state for the byte at the input.
  always_comb begin
    logic          ok;
    logic          done;
    logic          do_start;
    logic          at_top;
    logic          do_vd;
    logic          was_key;
    logic [LENGTH_BITS-1:0] rem_dec;
    logic [31:0]   bc_base;

    ok       = 1'b1;
    done     = 1'b0;
    do_start = 1'b0;
    at_top   = 1'b0;
    do_vd    = 1'b0;
    was_key  = 1'b0;
    push     = 1'b0;
    waddr    = sp;
    wdata    = 1'b0;
    rem_dec  = (rem != '0) ? rem - 1'b1 : rem;

    mode_next   = mode;
    rem_next    = rem;
    tkind_next  = (mode == M_IDLE) ? KIND_STRING : tkind;
    sp_next     = (mode == M_IDLE) ? '0 : sp;
    is_key_next = (mode == M_IDLE) ? 1'b0 : is_key;
    bc_base     = (mode == M_IDLE) ? 32'd0 : bcnt;
    bcnt_next   = (bc_base == 32'hFFFF_FFFF) ? bc_base : bc_base + 32'd1;

    unique case (mode)
      M_IDLE: begin
        do_start = 1'b1;
        at_top   = 1'b1;
      end
      M_ELEM: begin
        if (sp == '0) begin
          ok = 1'b0;
        end else if (data_byte == CH_E) begin
          sp_next = sp - 1'b1;
          do_vd   = 1'b1;
        end else if (top_bit) begin
          // Inside a dict every entry opens with a string key.
          if (is_dig) begin
            do_start    = 1'b1;
            is_key_next = 1'b1;
          end else begin
            ok = 1'b0;
          end
        end else begin
          do_start = 1'b1;
        end
      end
      M_VALUE: begin
        do_start = 1'b1;
      end
      M_INT_SIGN: begin
        if (data_byte == CH_MINUS) mode_next = M_INT_NEG;
        else if (is_dig) mode_next = M_INT_DIG;
        else if (data_byte == CH_E) do_vd = 1'b1;
        else ok = 1'b0;
      end
      M_INT_NEG: begin
        if ((data_byte >= CH_1) && (data_byte <= CH_9)) mode_next = M_INT_DIG;
        else if (data_byte == CH_E) do_vd = 1'b1;
        else ok = 1'b0;
      end
      M_INT_DIG: begin
        if (is_dig) mode_next = M_INT_DIG;
        else if (data_byte == CH_E) do_vd = 1'b1;
        else ok = 1'b0;
      end
      M_STR_LEN: begin
        if (is_dig) begin
          if (too_long) ok = 1'b0;
          else rem_next = len_n[LENGTH_BITS-1:0];
        end else if (data_byte == CH_COLON) begin
          if (rem == '0) do_vd = 1'b1;
          else mode_next = M_STR_BODY;
        end else begin
          ok = 1'b0;
        end
      end
      M_STR_BODY: begin
        rem_next = rem_dec;
        if (rem_dec == '0) do_vd = 1'b1;
      end
      default: ok = 1'b0;
    endcase

    // A value has ended: close the object or go back to its container.
    if (do_vd) begin
      was_key     = is_key_next;
      is_key_next = 1'b0;
      if (sp_next == '0) begin
        mode_next = M_IDLE;
        done      = 1'b1;
      end else begin
        mode_next = was_key ? M_VALUE : M_ELEM;
      end
    end

    // Start of a new value at this byte.
    if (do_start) begin
      if (data_byte == CH_I) begin
        if (at_top) tkind_next = KIND_INTEGER;
        mode_next = M_INT_SIGN;
      end else if ((data_byte == CH_L) || (data_byte == CH_D)) begin
        if (at_top) tkind_next = (data_byte == CH_D) ? KIND_DICT : KIND_LIST;
        if ((DW'(sp_next) >= DW'(depth_limit)) || (sp_next == AW'(STACK_DEPTH - 1))) begin
          ok = 1'b0;
        end else begin
          push      = 1'b1;
          waddr     = sp_next;
          wdata     = (data_byte == CH_D);
          sp_next   = sp_next + 1'b1;
          mode_next = M_ELEM;
        end
      end else if (is_dig) begin
        if (at_top) tkind_next = KIND_STRING;
        if (too_long) ok = 1'b0;
        else rem_next = LENGTH_BITS'(dval);
        mode_next = M_STR_LEN;
      end else begin
        ok = 1'b0;
      end
    end

    if (ok && !done && end_of_input) ok = 1'b0;

    // Resolve the status; an error clears the parse state.
    if (!ok) begin
      status_next = ST_ERR;
      mode_next   = M_IDLE;
      sp_next     = '0;
      rem_next    = '0;
      is_key_next = 1'b0;
    end else if (done) begin
      status_next = ST_DONE;
      mode_next   = M_IDLE;
    end else begin
      status_next = ST_BUSY;
    end
  end

  always_comb begin
    res_new.status       = status_next;
    res_new.object_bytes = bcnt_next;
    res_new.object_kind  = tkind_next;
    res_new.nesting      = 7'(sp_next);
  end

  // Read address follows the stack pointer that the next byte will see.
  assign sp_eff = accept ? sp_next : sp;
  assign raddr  = (sp_eff == '0) ? '0 : sp_eff - 1'b1;

  // Nesting stack memory with registered read.
  always_ff @(posedge clk) begin
    if (accept && push) begin
      kind_stack[waddr] <= wdata;
    end
    rd_q       <= kind_stack[raddr];
    fwd_data_q <= wdata;
  end

  // Forward the pushed kind when the read hits the entry being written.
  always_ff @(posedge clk) begin
    if (rst) begin
      fwd_q <= 1'b0;
    end else begin
      fwd_q <= accept && push && (waddr == raddr);
    end
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      depth_limit       <= DEPTH_LIMIT_RESET;
      max_string_length <= MAX_STRING_LENGTH_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_DEPTH_LIMIT:       depth_limit       <= cfg_data[6:0];
        CFG_MAX_STRING_LENGTH: max_string_length <= cfg_data;
        default: ;
      endcase
    end
  end

  // Parser state registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      mode   <= M_IDLE;
      sp     <= '0;
      rem    <= '0;
      is_key <= 1'b0;
      bcnt   <= '0;
      tkind  <= KIND_STRING;
    end else if (accept) begin
      mode   <= mode_next;
      sp     <= sp_next;
      rem    <= rem_next;
      is_key <= is_key_next;
      bcnt   <= bcnt_next;
      tkind  <= tkind_next;
    end
  end

  // Output register with a skid register behind it.
  assign item_ready = !skid_v;

  always_ff @(posedge clk) begin
    if (rst) begin
      main_v <= 1'b0;
      skid_v <= 1'b0;
    end else if (out_fire) begin
      if (skid_v) begin
        main_q <= skid_q;
        skid_v <= 1'b0;
      end else if (accept) begin
        main_q <= res_new;
      end else begin
        main_v <= 1'b0;
      end
    end else if (accept) begin
      if (!main_v) begin
        main_q <= res_new;
        main_v <= 1'b1;
      end else begin
        skid_q <= res_new;
        skid_v <= 1'b1;
      end
    end
  end

  assign result_valid = main_v;
  assign status       = main_q.status;
  assign object_bytes = main_q.object_bytes;
  assign object_kind  = main_q.object_kind;
  assign nesting      = main_q.nesting;

  // The skid register only fills behind a full output register.
  a_skid_behind_main: assert property (@(posedge clk) disable iff (rst) skid_v |-> main_v)
    else $error("skid register holds a result while the output register is empty");

  // Between objects the stack is empty.
  a_idle_empty: assert property (@(posedge clk) disable iff (rst) (mode == M_IDLE) |-> (sp == '0))
    else $error("stack pointer nonzero while expecting a new object");

  // Element mode always sits inside a container.
  a_elem_nested: assert property (@(posedge clk) disable iff (rst) (mode == M_ELEM) |-> (sp != '0))
    else $error("element mode with an empty stack");

  // An error result reports no nesting.
  a_err_flat: assert property (@(posedge clk) disable iff (rst)
    (result_valid && (status == ST_ERR)) |-> (nesting == 7'd0))
    else $error("error result with nonzero nesting");

endmodule
